[sv/bpfa_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// bpfa_pkg
// Shared codes, the result item type and the bit search helper of the page
// frame allocator.
// ============================================================================

package bpfa_pkg;

    // Pages are grouped into bitmap words of this many bits.
    localparam int WORD_BITS = 32;
    localparam int WORD_IDX_W = 5;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAME  = 2'd3;

    // One result item.
    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic [12:0] free_pages;
    } res_t;

    // Position of the lowest set bit of a word; zero when no bit is set.
    function automatic logic [WORD_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = WORD_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[sv/bpfa_cmd_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// bpfa_cmd_if
// Command channel of the page frame allocator: valid, ready and one item.
// ============================================================================

interface bpfa_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] page_addr;

    modport source (output valid, output cmd, output page_addr, input ready);
    modport sink (input valid, input cmd, input page_addr, output ready);
endinterface

[sv/bpfa_rsp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// bpfa_rsp_if
// Result channel of the page frame allocator: valid, ready and one item.
// ============================================================================

interface bpfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_addr;
    logic [1:0]  status;
    logic [12:0] free_pages;

    modport source (output valid, output result_addr, output status, output free_pages,
                    input ready);
    modport sink (input valid, input result_addr, input status, input free_pages,
                  output ready);
endinterface

[sv/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
// ============================================================================
// bitmap_page_frame_allocator
// First-fit physical page frame allocator over a bitmap with one bit per page.
// ============================================================================
//
// The block keeps one bit per page frame, set when the page is free, and
// starts out with every page used and a free count of zero. Each command item
// gives exactly one result item: allocate returns the byte address of the
// lowest free page and marks it used, free and reserve set or clear the bit
// of the page that holds page_addr, and every result carries the free count
// after the command. An allocate, free or reserve that changes a bit goes
// through these steps from acceptance to the result being offered: one per
// level of the three-level bitmap walk (a registered read of the summary
// RAM twice, then of the map RAM), one for the read-modify-write of
// the map word and its summary word, one for the top summary word, and one
// for the hand-off into the output register. Allocate on an empty map, free
// or reserve beyond the map, and the unused command code go straight to the
// hand-off; free or reserve of a bit already in the requested state skips the writes.
// One command is in flight at a time, and a new one is taken while the
// previous result still waits in the output register. Nothing needs clearing
// after reset: a bitmap or summary word whose parent summary bit is clear is
// read as zero, so the block is ready as soon as reset is released.
// PAGE_BYTES must be a power of two.
//
// ============================================================================

module bitmap_page_frame_allocator #(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    bpfa_cmd_if.sink   req,
    bpfa_rsp_if.source rsp
);

    // ------------------------------------------------------------------------
    // Geometry. Level 0 is the bitmap itself, one bit per page. Level 1 holds
    // one bit per level 0 word, set when that word has a free page. Level 2
    // does the same for level 1 words, and a register of at most 32 bits does
    // it for level 2 words. Levels 1 and 2 share one RAM, level 2 placed
    // after level 1.
    // ------------------------------------------------------------------------
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PN_W       = 32 - PAGE_SHIFT;
    localparam int W0         = (NUM_PAGES + 31) / 32;
    localparam int W1         = (W0 + 31) / 32;
    localparam int W2         = (W1 + 31) / 32;
    localparam int T_W        = (W2 > 1) ? $clog2(W2) : 1;
    localparam int PG_W       = 15 + T_W;
    localparam int AW0        = (W0 > 1) ? $clog2(W0) : 1;
    localparam int SD         = W1 + W2;
    localparam int SAW        = (SD > 1) ? $clog2(SD) : 1;
    localparam int CW         = $clog2(NUM_PAGES + 1);

    // ------------------------------------------------------------------------
    // Sequencer states. IDLE takes a command and starts the level 2 read,
    // RD1 and RD0 descend one level each, UPD reads the map word and writes
    // it back with its level 1 word, WR2 writes the level 2 word and the top
    // bits, and RESP hands the result to the output register.
    // ------------------------------------------------------------------------
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD1  = 6'b000010,
        S_RD0  = 6'b000100,
        S_UPD  = 6'b001000,
        S_WR2  = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [1:0]      op_reg;
    logic [1:0]      op_next;
    logic [PG_W-1:0] page_reg;
    logic [PG_W-1:0] page_next;
    logic [31:0]     w2_reg;
    logic [31:0]     w2_next;
    logic [31:0]     w1_reg;
    logic [31:0]     w1_next;
    logic            new1_zero_reg;
    logic            new1_zero_next;
    logic [W2-1:0]   top_reg;
    logic [W2-1:0]   top_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    bpfa_pkg::res_t  res_reg;
    bpfa_pkg::res_t  res_next;

    // RAM ports.
    logic            map_wr_en;
    logic [AW0-1:0]  map_wr_addr;
    logic [31:0]     map_wr_data;
    logic            map_rd_en;
    logic [AW0-1:0]  map_rd_addr;
    logic [31:0]     map_rd_data;
    logic            sum_wr_en;
    logic [SAW-1:0]  sum_wr_addr;
    logic [31:0]     sum_wr_data;
    logic            sum_rd_en;
    logic [SAW-1:0]  sum_rd_addr;
    logic [31:0]     sum_rd_data;

    logic            res_ready;

    // ------------------------------------------------------------------------
    // Datapath terms.
    // ------------------------------------------------------------------------
    logic [PN_W-1:0]  req_pn;
    logic [PG_W-1:0]  req_page;
    logic             req_in_range;
    logic [T_W-1:0]   top_first;
    logic [T_W-1:0]   req_i2;
    logic             is_alloc;
    logic             set_op;
    logic [T_W-1:0]   pg_i2;
    logic [4:0]       pg_j;
    logic [4:0]       pg_k;
    logic [4:0]       pg_b;
    logic [31:0]      eff2;
    logic [31:0]      eff1;
    logic [31:0]      eff0;
    logic [4:0]       j_sel;
    logic [4:0]       k_sel;
    logic [4:0]       b_sel;
    logic             bit_now;
    logic             chg;
    logic [31:0]      mask_b;
    logic [31:0]      mask_k;
    logic [31:0]      mask_j;
    logic [31:0]      new0;
    logic [31:0]      new1;
    logic [31:0]      new2;

    // The page number of an incoming free or reserve; offset bits drop out.
    assign req_pn       = req.page_addr[31:PAGE_SHIFT];
    assign req_page     = PG_W'(req_pn);
    assign req_in_range = 32'(req_pn) < 32'(NUM_PAGES);
    assign req_i2       = req_page[PG_W-1:15];
    assign top_first    = T_W'(bpfa_pkg::lowest_set(32'(top_reg)));

    assign is_alloc = (op_reg == bpfa_pkg::CMD_ALLOC);
    assign set_op   = (op_reg == bpfa_pkg::CMD_FREE);

    assign pg_i2 = page_reg[PG_W-1:15];
    assign pg_j  = page_reg[14:10];
    assign pg_k  = page_reg[9:5];
    assign pg_b  = page_reg[4:0];

    // A word counts only while its parent summary bit is set; otherwise its
    // RAM contents are stale and it reads as all used.
    assign eff2 = top_reg[pg_i2] ? sum_rd_data : '0;
    assign eff1 = w2_reg[pg_j] ? sum_rd_data : '0;
    assign eff0 = w1_reg[pg_k] ? map_rd_data : '0;

    // Allocate follows the lowest set bit at each level; free and reserve
    // follow the bits of their page number.
    assign j_sel = is_alloc ? bpfa_pkg::lowest_set(eff2) : pg_j;
    assign k_sel = is_alloc ? bpfa_pkg::lowest_set(eff1) : pg_k;
    assign b_sel = is_alloc ? bpfa_pkg::lowest_set(eff0) : pg_b;

    assign bit_now = eff0[b_sel];
    assign chg     = set_op ? !bit_now : (is_alloc || bit_now);

    assign mask_b = 32'd1 << b_sel;
    assign mask_k = 32'd1 << pg_k;
    assign mask_j = 32'd1 << pg_j;

    // Setting a bit marks every summary level above it. Clearing one clears
    // a summary bit only when the word below it has just gone to zero.
    assign new0 = set_op ? (eff0 | mask_b) : (eff0 & ~mask_b);
    assign new1 = set_op ? (w1_reg | mask_k)
                         : ((new0 == '0) ? (w1_reg & ~mask_k) : w1_reg);
    assign new2 = set_op ? (w2_reg | mask_j)
                         : (new1_zero_reg ? (w2_reg & ~mask_j) : w2_reg);

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        w2_next        = w2_reg;
        w1_next        = w1_reg;
        new1_zero_next = new1_zero_reg;
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        map_wr_en      = 1'b0;
        map_wr_addr    = AW0'({pg_i2, pg_j, pg_k});
        map_wr_data    = new0;
        map_rd_en      = 1'b0;
        map_rd_addr    = AW0'({pg_i2, pg_j, k_sel});
        sum_wr_en      = 1'b0;
        sum_wr_addr    = SAW'({pg_i2, pg_j});
        sum_wr_data    = new1;
        sum_rd_en      = 1'b0;
        sum_rd_addr    = SAW'({pg_i2, j_sel});

        unique case (state_reg)
            S_IDLE:
            begin
                res_next.result_addr = '0;
                res_next.status      = bpfa_pkg::ST_DONE;
                res_next.free_pages  = 13'(cnt_reg);
                if (req.valid)
                begin
                    op_next = req.cmd;
                    priority if (req.cmd == bpfa_pkg::CMD_ALLOC)
                    begin
                        if (top_reg == '0)
                        begin
                            res_next.status = bpfa_pkg::ST_EMPTY;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            page_next   = {top_first, 15'd0};
                            sum_rd_en   = 1'b1;
                            sum_rd_addr = SAW'(W1) + SAW'(top_first);
                            state_next  = S_RD1;
                        end
                    end
                    else if (req.cmd == bpfa_pkg::CMD_FREE ||
                             req.cmd == bpfa_pkg::CMD_RESERVE)
                    begin
                        if (!req_in_range)
                        begin
                            res_next.status = bpfa_pkg::ST_RANGE;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            page_next   = req_page;
                            sum_rd_en   = 1'b1;
                            sum_rd_addr = SAW'(W1) + SAW'(req_i2);
                            state_next  = S_RD1;
                        end
                    end
                    else
                    begin
                        // The unused code changes nothing.
                        state_next = S_RESP;
                    end
                end
            end

            S_RD1:
            begin
                w2_next          = eff2;
                page_next[14:10] = j_sel;
                sum_rd_en        = 1'b1;
                state_next       = S_RD0;
            end

            S_RD0:
            begin
                w1_next        = eff1;
                page_next[9:5] = k_sel;
                map_rd_en      = 1'b1;
                state_next     = S_UPD;
            end

            S_UPD:
            begin
                page_next[4:0] = b_sel;
                new1_zero_next = (new1 == '0);
                if (chg)
                begin
                    map_wr_en  = 1'b1;
                    sum_wr_en  = 1'b1;
                    state_next = S_WR2;
                end
                else
                begin
                    res_next.result_addr = '0;
                    res_next.status      = bpfa_pkg::ST_SAME;
                    res_next.free_pages  = 13'(cnt_reg);
                    state_next           = S_RESP;
                end
            end

            S_WR2:
            begin
                sum_wr_en       = 1'b1;
                sum_wr_addr     = SAW'(W1) + SAW'(pg_i2);
                sum_wr_data     = new2;
                top_next[pg_i2] = (new2 != '0);
                cnt_next        = set_op ? (cnt_reg + 1'b1) : (cnt_reg - 1'b1);
                res_next.result_addr = is_alloc ? (32'(page_reg) << PAGE_SHIFT) : '0;
                res_next.status      = bpfa_pkg::ST_DONE;
                res_next.free_pages  = 13'(cnt_next);
                state_next           = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        page_reg      <= page_next;
        w2_reg        <= w2_next;
        w1_reg        <= w1_next;
        new1_zero_reg <= new1_zero_next;
        res_reg       <= res_next;
    end

    // ------------------------------------------------------------------------
    // Storage: the page bitmap and the two lower summary levels.
    // ------------------------------------------------------------------------
    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (W0)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data)
    );

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (SD)
    ) u_sum_ram (
        .clk     (clk),
        .wr_en   (sum_wr_en),
        .wr_addr (sum_wr_addr),
        .wr_data (sum_wr_data),
        .rd_en   (sum_rd_en),
        .rd_addr (sum_rd_addr),
        .rd_data (sum_rd_data)
    );

    // ------------------------------------------------------------------------
    // Output register: lets the next command start while a result waits.
    // ------------------------------------------------------------------------
    bpfa_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (state_reg == S_RESP),
        .res_ready (res_ready),
        .res       (res_reg),
        .rsp       (rsp)
    );

endmodule

[sv/bpfa_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// bpfa_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ============================================================================

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/bpfa_out_stage.sv]
`timescale 1ns / 1ps
// ============================================================================
// bpfa_out_stage
// Output register of the allocator: holds one finished result item until the
// result channel takes it.
// ============================================================================

module bpfa_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  bpfa_pkg::res_t    res,
    bpfa_rsp_if.source        rsp
);

    logic           valid_reg;
    logic           valid_next;
    bpfa_pkg::res_t data_reg;

    assign res_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.result_addr = data_reg.result_addr;
    assign rsp.status      = data_reg.status;
    assign rsp.free_pages  = data_reg.free_pages;

endmodule

[verif/tb_bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_bitmap_page_frame_allocator
// Self-checking testbench for the first-fit bitmap page frame allocator.
// ============================================================================
//
// The testbench keeps its own copy of the page bitmap and the free count.
// Each command item that the block accepts is applied to that copy, and the
// result item that the copy predicts is queued. Every result item that the
// block hands over is checked field by field against the oldest queued one.
// A short directed part covers the empty map, addresses beyond the map,
// redundant free and reserve, first-fit order and the unused command code.
// Random churn phases then build the map up, churn it and drain it. One
// phase holds the result channel off for a long stretch so that the block
// fills and stalls its command channel.
//
// ============================================================================

module tb_bitmap_page_frame_allocator;

    localparam int NUM_PAGES   = 4096;
    localparam int PAGE_BYTES  = 4096;
    // A long hold-off of the result channel, in cycles.
    localparam int HOLD_CYCLES = 300;
    // Far above the slowest correct run: about 1000 items, each with the
    // longest gap, the longest stall and the block's own pass through its states.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n;

    bpfa_cmd_if cmd_ch ();
    bpfa_rsp_if rsp_ch ();

    bitmap_page_frame_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predicted allocator state and the results still owed by the block.
    // ------------------------------------------------------------------------

    // One bit per page, set when the page is free. Every page starts used.
    bit [NUM_PAGES-1:0] page_free = '0;
    int                 free_count = 0;
    bpfa_pkg::res_t     outcome_q[$];

    int fail_count  = 0;
    int cycle_count = 0;

    // When set, the sender or the receiver runs without gaps for a while.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // The test bumps hold_seq to ask the receiver for a long hold-off.
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;

    // Applies one command to the predicted bitmap and returns the result item
    // that the block must produce for it.
    function automatic bpfa_pkg::res_t apply_page_cmd(input logic [1:0] c,
                                                      input logic [31:0] a);
        bpfa_pkg::res_t r;
        int unsigned    pg;
        int             k;
        bit             found;
        bit             want_free;
        r = '0;
        r.status = bpfa_pkg::ST_DONE;
        found = 1'b0;
        pg = 0;
        case (c)
            bpfa_pkg::CMD_ALLOC:
            begin
                // First fit: the lowest set bit wins.
                for (k = 0; k < NUM_PAGES; k++)
                begin
                    if (!found && page_free[k])
                    begin
                        found = 1'b1;
                        pg = k;
                    end
                end
                if (found)
                begin
                    page_free[pg] = 1'b0;
                    free_count--;
                    r.result_addr = 32'(64'(pg) * 64'(PAGE_BYTES));
                end
                else
                begin
                    r.status = bpfa_pkg::ST_EMPTY;
                end
            end
            bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE:
            begin
                // Offset bits below the page size do not matter.
                pg = a / PAGE_BYTES;
                want_free = (c == bpfa_pkg::CMD_FREE);
                if (pg >= NUM_PAGES)
                begin
                    r.status = bpfa_pkg::ST_RANGE;
                end
                else if (page_free[pg] == want_free)
                begin
                    r.status = bpfa_pkg::ST_SAME;
                end
                else
                begin
                    page_free[pg] = want_free;
                    free_count += want_free ? 1 : -1;
                end
            end
            default:
            begin
                // The unused code leaves everything alone and reports done.
            end
        endcase
        r.free_pages = 13'(free_count);
        return r;
    endfunction

    // Idle length between items: mostly none, often short, now and then long.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    // Byte address inside page pg with a random offset.
    function automatic logic [31:0] addr_in_page(input int pg);
        return 32'(pg) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers one command item, waits for it to be taken, records the
    // predicted result and then idles for a random gap. With no gap, valid
    // stays high into the next item.
    // ------------------------------------------------------------------------
    task automatic issue_cmd(input logic [1:0] c, input logic [31:0] a);
        int gap;
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c;
        cmd_ch.page_addr <= a;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        outcome_q.push_back(apply_page_cmd(c, a));
        gap = pick_gap(tx_calm);
        if (gap != 0)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.cmd       <= 2'($urandom);
            cmd_ch.page_addr <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready is driven in this one process. A requested hold-off
    // takes priority, then any random stall under way, and otherwise ready
    // is mostly high with an occasional new stall.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_seq != hold_seen)
        begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_calm || $urandom_range(99) >= 25)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            stall_left   <= pick_gap(1'b0);
            rsp_ch.ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Sampling at the rising edge sees the values that held
    // during the cycle, so each handshake is seen exactly once.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        bpfa_pkg::res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("%0t: result item with none outstanding, addr 0x%0h status %0d",
                             $realtime, rsp_ch.result_addr, rsp_ch.status);
                end
            end
            else
            begin
                want = outcome_q.pop_front();
                if (rsp_ch.result_addr !== want.result_addr)
                begin
                    note_mismatch("result_addr", want.result_addr, rsp_ch.result_addr);
                end
                if (rsp_ch.status !== want.status)
                begin
                    note_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
                end
                if (rsp_ch.free_pages !== want.free_pages)
                begin
                    note_mismatch("free_pages", 32'(want.free_pages), 32'(rsp_ch.free_pages));
                end
            end
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_page_frame_allocator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Fresh map: every page is used, so allocate finds nothing and reserve is
    // redundant.
    task automatic test_empty_map();
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0000_0000);
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0000_5123);
    endtask

    // Page numbers at or past the end of the map are flagged and ignored.
    task automatic test_range_check();
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h0100_0000);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'hFFFF_FFFF);
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h8000_0000);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0100_0FFF);
    endtask

    // Free both end pages, including the one with all offset bits set, and
    // repeat commands so that they hit a bit already in that state.
    task automatic test_redundant_ops();
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h0000_0FFF);
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h0000_0000);
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h00FF_FFFF);
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h00FF_F000);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0001_2ABC);
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h0000_7000);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0000_7FFF);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0000_7001);
    endtask

    // Allocations must come back lowest page first until the map is empty.
    task automatic test_first_fit();
        issue_cmd(bpfa_pkg::CMD_FREE, 32'h0002_8000);
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'h1234_5678);
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0000_0000);
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        issue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0000_0000);
        issue_cmd(bpfa_pkg::CMD_RESERVE, 32'h0002_8000);
    endtask

    // The spare command code does nothing and reports done.
    task automatic test_unused_cmd();
        issue_cmd(bpfa_pkg::CMD_UNUSED, 32'h5555_AAAA);
        issue_cmd(bpfa_pkg::CMD_UNUSED, 32'hFFFF_FFFF);
    endtask

    // ------------------------------------------------------------------------
    // Random churn. Most pages come from a small low window so that frees,
    // reserves and first-fit allocations keep running into each other; a few
    // land anywhere in the map or beyond it.
    // ------------------------------------------------------------------------
    task automatic test_random_churn(input int n_items, input int alloc_pct, input int free_pct);
        int          i;
        int          r;
        int          pg;
        logic [1:0]  c;
        logic [31:0] a;
        for (i = 0; i < n_items; i++)
        begin
            // Switch the idle pattern every so often so that stretches with
            // no gaps at all alternate with busy, gappy ones.
            if (i % 64 == 0)
            begin
                tx_calm = ($urandom_range(3) == 0);
                rx_calm <= ($urandom_range(3) == 0);
            end
            r  = $urandom_range(99);
            pg = ($urandom_range(3) != 0) ? $urandom_range(63) : $urandom_range(NUM_PAGES - 1);
            a  = addr_in_page(pg);
            if (r < alloc_pct)
            begin
                c = bpfa_pkg::CMD_ALLOC;
                a = $urandom;
            end
            else if (r < alloc_pct + free_pct)
            begin
                c = bpfa_pkg::CMD_FREE;
            end
            else if (r < 93)
            begin
                c = bpfa_pkg::CMD_RESERVE;
            end
            else if (r < 97)
            begin
                c = r[0] ? bpfa_pkg::CMD_FREE : bpfa_pkg::CMD_RESERVE;
                a = $urandom_range(32'hFFFF_FFFF, NUM_PAGES * PAGE_BYTES);
            end
            else
            begin
                c = bpfa_pkg::CMD_UNUSED;
                a = $urandom;
            end
            issue_cmd(c, a);
        end
        tx_calm = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the block fills and drops ready.
    task automatic test_output_stall();
        int i;
        tx_calm = 1'b1;
        hold_seq <= hold_seq + 1;
        for (i = 0; i < 12; i++)
        begin
            issue_cmd((i % 3 == 2) ? bpfa_pkg::CMD_ALLOC : bpfa_pkg::CMD_FREE,
                      addr_in_page($urandom_range(95)));
        end
        tx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= bpfa_pkg::CMD_ALLOC;
        cmd_ch.page_addr <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_map();
        test_range_check();
        test_redundant_ops();
        test_first_fit();
        test_unused_cmd();

        // Build the map up, churn it, stall the output, then drain it until
        // allocations start to find it empty.
        test_random_churn(300, 15, 55);
        test_random_churn(330, 35, 35);
        test_output_stall();
        test_random_churn(320, 60, 15);

        cmd_ch.valid <= 1'b0;
        while (outcome_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("bitmap_page_frame_allocator test passed");
        end
        else
        begin
            $display("bitmap_page_frame_allocator test failed");
        end
        $finish;
    end

endmodule

[files.f]
sv/bpfa_pkg.sv
sv/bpfa_cmd_if.sv
sv/bpfa_rsp_if.sv
sv/bpfa_ram.sv
sv/bpfa_out_stage.sv
sv/bitmap_page_frame_allocator.sv
verif/tb_bitmap_page_frame_allocator.sv
